// ===== hw/rtl/ballp_pkg.sv =====
// ----------------------------------------------------------------------------
// ballp_pkg
// shared types, character codes and sizes of the ball position line parser
// ----------------------------------------------------------------------------
package ballp_pkg;

	localparam int LINE_CAPACITY = 24;
	localparam int QUEUE_DEPTH   = 2;
	localparam int CFG_W         = 10;
	localparam int COORD_W       = 11;
	localparam int COUNT_W       = 32;
	localparam int OUT_TDATA_W   = 56;

	localparam logic [CFG_W-1:0] MAX_X_RESET = 10'd639;
	localparam logic [CFG_W-1:0] MAX_Y_RESET = 10'd479;
	localparam logic [9:0]       VALUE_LIMIT = 10'd999;

	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	localparam logic [2:0] PREFIX_LAST = 3'd4;

	typedef enum logic [0:0] {
		REG_MAX_X = 1'b0,
		REG_MAX_Y = 1'b1
	} reg_idx_t;

	// one classified byte passed from the front to the back
	typedef struct packed {
		logic       is_end;
		logic [7:0] data;
	} cmd_t;

	// expected text "BALL," at the head of a line
	function automatic logic [7:0] prefix_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0:    c = 8'h42;
			3'd1:    c = 8'h41;
			3'd2:    c = 8'h4C;
			3'd3:    c = 8'h4C;
			3'd4:    c = CHAR_COMMA;
			default: c = 8'hFF;
		endcase
		return c;
	endfunction

endpackage

// ===== hw/rtl/ball_position_line_parser.sv =====
// ----------------------------------------------------------------------------
// ball_position_line_parser
// assembles received text lines and reports parsed BALL,x,y frames
// ----------------------------------------------------------------------------
// throughput: one byte per cycle; a newline holds the line engine while it scans the
// line ram one character a cycle, and a newline waits while a result is still unsent
// reset: clears line length, discard flag, frame counter and output valid; max_x and
// max_y return to 639 and 479; the line ram is not cleared
module ball_position_line_parser #(
	parameter int LINE_CAPACITY = ballp_pkg::LINE_CAPACITY
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,   // rx_byte
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// detected, pos_x, pos_y, frame_count, zero pad
	output logic [ballp_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input  logic                                cfg_we,
	input  logic [0:0]                          cfg_index,
	input  logic [ballp_pkg::CFG_W-1:0]         cfg_data
);

	logic [ballp_pkg::CFG_W-1:0] max_x_q;
	logic [ballp_pkg::CFG_W-1:0] max_y_q;
	logic                        cmd_valid;
	logic                        cmd_ready;
	ballp_pkg::cmd_t             cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_x_q <= ballp_pkg::MAX_X_RESET;
			max_y_q <= ballp_pkg::MAX_Y_RESET;
		end else if (cfg_we) begin
			unique case (ballp_pkg::reg_idx_t'(cfg_index))
				ballp_pkg::REG_MAX_X: max_x_q <= cfg_data;
				ballp_pkg::REG_MAX_Y: max_y_q <= cfg_data;
				default:              max_x_q <= max_x_q;
			endcase
		end
	end

	ballp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_ready (cmd_ready)
	);

	ballp_back #(
		.LINE_CAPACITY (LINE_CAPACITY)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_ready (cmd_ready),
		.max_x     (max_x_q),
		.max_y     (max_y_q),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

`ifndef SYNTHESIS
	// a detected target never carries a negative x
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> !m_tdata[11])
		else $error("detected frame with negative x");

	// a no-target frame carries -1 in both coordinates
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[0]) |-> (m_tdata[22:1] == '1))
		else $error("no-target frame with coordinates other than -1,-1");

	// a detected target lies within the configured frame
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0] && !cfg_we && !$past(cfg_we)) |->
		((m_tdata[10:1] <= max_x_q) && (m_tdata[21:12] <= max_y_q)))
		else $error("detected target outside the configured frame");
`endif

endmodule

// ===== hw/rtl/ballp_ram.sv =====
// ----------------------------------------------------------------------------
// ballp_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module ballp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = ballp_pkg::LINE_CAPACITY
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/ballp_queue.sv =====
// ----------------------------------------------------------------------------
// ballp_queue
// short command queue between the byte classifier and the line engine
// ----------------------------------------------------------------------------
module ballp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	input  ballp_pkg::cmd_t   push_cmd,
	output logic              push_ready,
	output logic              pop_valid,
	output ballp_pkg::cmd_t   pop_cmd,
	input  logic              pop_ready
);

	localparam int AW = $clog2(ballp_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(ballp_pkg::QUEUE_DEPTH + 1);

	ballp_pkg::cmd_t entry_q [ballp_pkg::QUEUE_DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != CW'(ballp_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(ballp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(ballp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/ballp_front.sv =====
// ----------------------------------------------------------------------------
// ballp_front
// byte classifier: drops carriage returns, marks newlines as line ends
// ----------------------------------------------------------------------------
module ballp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // rx_byte
	output logic              cmd_valid,
	output ballp_pkg::cmd_t   cmd,
	input  logic              cmd_ready
);

	ballp_pkg::cmd_t push_cmd;
	logic            push_valid;
	logic            push_ready;

	assign push_valid      = s_tvalid && (s_tdata != ballp_pkg::CHAR_CR);
	assign push_cmd.is_end = (s_tdata == ballp_pkg::CHAR_LF);
	assign push_cmd.data   = s_tdata;
	assign s_tready        = push_ready;

	ballp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.push_ready (push_ready),
		.pop_valid  (cmd_valid),
		.pop_cmd    (cmd),
		.pop_ready  (cmd_ready)
	);

endmodule

// ===== hw/rtl/ballp_back.sv =====
// ----------------------------------------------------------------------------
// ballp_back
// line engine: stores characters, scans a finished line, holds the result
// ----------------------------------------------------------------------------
module ballp_back #(
	parameter int LINE_CAPACITY = ballp_pkg::LINE_CAPACITY
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_valid,
	input  ballp_pkg::cmd_t                     cmd,
	output logic                                cmd_ready,
	input  logic [ballp_pkg::CFG_W-1:0]         max_x,
	input  logic [ballp_pkg::CFG_W-1:0]         max_y,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [ballp_pkg::OUT_TDATA_W-1:0]   m_tdata
);

	localparam int LEN_W = $clog2(LINE_CAPACITY);
	localparam int CNT_W = $clog2(LINE_CAPACITY + 1);
	localparam int CW    = ballp_pkg::COORD_W;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

	typedef enum logic [4:0] {
		PH_PREFIX = 5'b00001,
		PH_XSIGN  = 5'b00010,
		PH_XDIG   = 5'b00100,
		PH_YSIGN  = 5'b01000,
		PH_YDIG   = 5'b10000
	} phase_t;

	state_t                         state_q;
	phase_t                         ph_q;
	phase_t                         ph_n;
	logic [LEN_W-1:0]               len_q;
	logic                           disc_q;
	logic [CNT_W-1:0]               cnt_q;
	logic                           vld_s1;
	logic [CNT_W-1:0]               idx_s1;
	logic [9:0]                     acc_q;
	logic [9:0]                     acc_n;
	logic                           neg_q;
	logic                           neg_n;
	logic                           nd_q;
	logic                           nd_n;
	logic [CW-1:0]                  x_q;
	logic [CW-1:0]                  x_n;
	logic [ballp_pkg::COUNT_W-1:0]  frames_q;
	logic                           out_valid_q;
	logic                           out_det_q;
	logic [CW-1:0]                  out_x_q;
	logic [CW-1:0]                  out_y_q;
	logic [ballp_pkg::COUNT_W-1:0]  out_cnt_q;

	logic                           take;
	logic                           line_full;
	logic                           wr_en;
	logic [7:0]                     rd_data;
	logic [7:0]                     ch;
	logic                           is_dig;
	logic [13:0]                    acc_mul;
	logic                           num_ok;
	logic [CW-1:0]                  num_val;
	logic                           in_x;
	logic                           first;
	logic [7:0]                     term;
	logic                           fail;
	logic                           ydone;
	logic                           finish;
	logic                           none;
	logic                           hit;
	logic                           emit;

	assign cmd_ready = (state_q == S_IDLE) && (!cmd.is_end || !out_valid_q);
	assign take      = cmd_valid && cmd_ready;
	assign line_full = (len_q == LEN_W'(LINE_CAPACITY - 1));
	assign wr_en     = take && !cmd.is_end && !disc_q && !line_full;

	ballp_ram #(
		.WIDTH (8),
		.DEPTH (LINE_CAPACITY)
	) u_line_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (len_q),
		.wr_data (cmd.data),
		.rd_addr (cnt_q[LEN_W-1:0]),
		.rd_data (rd_data)
	);

	// past the stored text a line reads as zero bytes
	assign ch      = (idx_s1 < CNT_W'(len_q)) ? rd_data : ballp_pkg::CHAR_NUL;
	assign is_dig  = (ch >= ballp_pkg::CHAR_ZERO) && (ch <= ballp_pkg::CHAR_NINE);
	assign acc_mul = {4'b0, acc_q} * 14'd10 + {10'b0, ch[3:0]};
	assign num_ok  = nd_q && (!neg_q || (acc_q == 10'd1));
	assign num_val = neg_q ? '1 : {1'b0, acc_q};
	assign in_x    = (ph_q == PH_XSIGN) || (ph_q == PH_XDIG);
	assign first   = (ph_q == PH_XSIGN) || (ph_q == PH_YSIGN);
	assign term    = in_x ? ballp_pkg::CHAR_COMMA : ballp_pkg::CHAR_NUL;

	always_comb begin
		ph_n  = ph_q;
		acc_n = acc_q;
		neg_n = neg_q;
		nd_n  = nd_q;
		x_n   = x_q;
		fail  = 1'b0;
		ydone = 1'b0;
		unique case (ph_q)
			PH_PREFIX: begin
				if (ch != ballp_pkg::prefix_char(idx_s1[2:0])) begin
					fail = 1'b1;
				end else if (idx_s1[2:0] == ballp_pkg::PREFIX_LAST) begin
					ph_n = PH_XSIGN;
				end
			end
			default: begin
				if (first && (ch == ballp_pkg::CHAR_MINUS)) begin
					neg_n = 1'b1;
					ph_n  = in_x ? PH_XDIG : PH_YDIG;
				end else if (is_dig) begin
					if (acc_mul > {4'b0, ballp_pkg::VALUE_LIMIT}) begin
						fail = 1'b1;
					end
					acc_n = acc_mul[9:0];
					nd_n  = 1'b1;
					ph_n  = in_x ? PH_XDIG : PH_YDIG;
				end else if ((ch != term) || !num_ok) begin
					fail = 1'b1;
				end else if (in_x) begin
					x_n   = num_val;
					acc_n = '0;
					neg_n = 1'b0;
					nd_n  = 1'b0;
					ph_n  = PH_YSIGN;
				end else begin
					ydone = 1'b1;
				end
			end
		endcase
	end

	assign finish = vld_s1 && (fail || ydone);
	assign none   = (x_q == '1) && neg_q;
	assign hit    = !x_q[CW-1] && (x_q[9:0] <= max_x) && !neg_q && (acc_q <= max_y);
	assign emit   = vld_s1 && ydone && (none || hit);

	always_ff @(posedge clk) begin
		if (take && cmd.is_end) begin
			ph_q  <= PH_PREFIX;
			acc_q <= '0;
			neg_q <= 1'b0;
			nd_q  <= 1'b0;
		end else if (vld_s1 && !finish) begin
			ph_q  <= ph_n;
			acc_q <= acc_n;
			neg_q <= neg_n;
			nd_q  <= nd_n;
			x_q   <= x_n;
		end
		if (emit) begin
			out_det_q <= hit;
			out_x_q   <= x_q;
			out_y_q   <= num_val;
			out_cnt_q <= frames_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			disc_q      <= 1'b0;
			cnt_q       <= '0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			frames_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					vld_s1 <= 1'b0;
					if (take) begin
						if (cmd.is_end) begin
							if (disc_q) begin
								disc_q <= 1'b0;
								len_q  <= '0;
							end else begin
								state_q <= S_SCAN;
								cnt_q   <= '0;
							end
						end else if (!disc_q) begin
							if (line_full) begin
								len_q  <= '0;
								disc_q <= 1'b1;
							end else begin
								len_q <= len_q + 1'b1;
							end
						end
					end
				end
				S_SCAN: begin
					if (finish) begin
						state_q <= S_IDLE;
						vld_s1  <= 1'b0;
						len_q   <= '0;
					end else begin
						vld_s1 <= 1'b1;
						idx_s1 <= cnt_q;
						cnt_q  <= cnt_q + 1'b1;
					end
					if (emit) begin
						frames_q    <= frames_q + 1'b1;
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_cnt_q, out_y_q, out_x_q, out_det_q};

endmodule

// ===== tb/sv/ball_position_line_parser_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ball_position_line_parser_test
// feeds text lines byte by byte to the parser, predicts every BALL,x,y
// frame in a scoreboard of its own and checks each output transaction
// field by field, across several max_x / max_y settings and random stalls
// ----------------------------------------------------------------------------
module ball_position_line_parser_test;
	import ballp_pkg::*;

	localparam int IDLE_PCT   = 12;
	localparam int SETTLE     = 64;
	localparam int HOLD_LEN   = 1500;
	localparam int QUIET_MAX  = 20000;
	localparam int PHASE_SIZE = 130;

	typedef struct packed {
		logic               detected;
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
		logic [COUNT_W-1:0] frame_count;
	} ball_report_t;

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [7:0]             s_tdata   = '0;   // rx_byte
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	// detected, pos_x, pos_y, frame_count, zero pad
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we    = 1'b0;
	logic [0:0]             cfg_index = '0;
	logic [CFG_W-1:0]       cfg_data  = '0;

	// parser state as seen by the scoreboard
	logic [7:0]       line_buf [LINE_CAPACITY];
	int               line_len    = 0;
	bit               skipping    = 1'b0;
	logic [31:0]      frames_seen = '0;
	logic [CFG_W-1:0] lim_x       = MAX_X_RESET;
	logic [CFG_W-1:0] lim_y       = MAX_Y_RESET;

	logic [7:0]   byte_queue [$];
	ball_report_t frames_due [$];
	int           errors    = 0;
	bit           steady    = 1'b0;
	bit           hold_req  = 1'b0;
	bit           hold_done = 1'b0;
	int           hold_left = 0;
	int           quiet     = 0;

	ball_position_line_parser DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] line_char(input int p);
		if (p < line_len)
			return line_buf[p];
		return CHAR_NUL;
	endfunction

	// decimal number with optional minus, ended by term
	function automatic bit scan_number(inout int p, input logic [7:0] term, output int val);
		int         q;
		bit         neg;
		int         acc;
		int         ndig;
		logic [7:0] c;
		q    = p;
		neg  = 1'b0;
		acc  = 0;
		ndig = 0;
		val  = 0;
		c    = line_char(q);
		if (c == CHAR_MINUS) begin
			neg = 1'b1;
			q++;
			c = line_char(q);
		end
		while (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			acc = acc * 10 + int'(c - CHAR_ZERO);
			if (acc > int'(VALUE_LIMIT))
				return 1'b0;
			q++;
			ndig++;
			c = line_char(q);
		end
		if (ndig == 0 || c != term)
			return 1'b0;
		if (neg && acc != 1)
			return 1'b0;
		val = neg ? -1 : acc;
		p   = q + 1;
		return 1'b1;
	endfunction

	// advances the line state by one received byte; 1 when a frame results
	function automatic bit parse_rx_byte(input logic [7:0] b, output ball_report_t r);
		logic [39:0] head;
		int          p;
		int          x;
		int          y;
		bit          none;
		bit          hit;
		head = "BALL,";
		r    = '0;
		if (b == CHAR_CR)
			return 1'b0;
		if (b == CHAR_LF) begin
			if (skipping) begin
				skipping = 1'b0;
				line_len = 0;
				return 1'b0;
			end
			for (int i = 0; i < 5; i++) begin
				if (line_char(i) != head[39-8*i -: 8]) begin
					line_len = 0;
					return 1'b0;
				end
			end
			p = 5;
			if (!scan_number(p, CHAR_COMMA, x) || !scan_number(p, CHAR_NUL, y)) begin
				line_len = 0;
				return 1'b0;
			end
			line_len = 0;
			none = (x == -1 && y == -1);
			hit  = (x >= 0 && x <= int'(lim_x) && y >= 0 && y <= int'(lim_y));
			if (!none && !hit)
				return 1'b0;
			frames_seen   = frames_seen + 1;
			r.detected    = hit;
			r.pos_x       = x[COORD_W-1:0];
			r.pos_y       = y[COORD_W-1:0];
			r.frame_count = frames_seen;
			return 1'b1;
		end
		if (skipping)
			return 1'b0;
		if (line_len >= LINE_CAPACITY - 1) begin
			line_len = 0;
			skipping = 1'b1;
			return 1'b0;
		end
		line_buf[line_len] = b;
		line_len++;
		return 1'b0;
	endfunction

	// sender
	always @(posedge clk) begin : drive
		ball_report_t rep;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				void'(byte_queue.pop_front());
				if (parse_rx_byte(s_tdata, rep))
					frames_due.push_back(rep);
			end
			if (!(s_tvalid && !s_tready)) begin
				if (byte_queue.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
					s_tvalid <= 1'b1;
					s_tdata  <= byte_queue[0];
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver, with one long hold-off on request
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_LEN;
			m_tready  <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin : monitor
		ball_report_t want;
		ball_report_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.detected    = m_tdata[0];
			got.pos_x       = m_tdata[11:1];
			got.pos_y       = m_tdata[22:12];
			got.frame_count = m_tdata[54:23];
			if (frames_due.size() == 0) begin
				$error("unexpected transaction: detected %0d x %0d y %0d count %0d",
					got.detected, $signed(got.pos_x), $signed(got.pos_y), got.frame_count);
				errors++;
			end else begin
				want = frames_due.pop_front();
				if (got.detected !== want.detected) begin
					$error("detected: expected %0d, got %0d", want.detected, got.detected);
					errors++;
				end
				if (got.pos_x !== want.pos_x) begin
					$error("pos_x: expected %0d, got %0d", $signed(want.pos_x),
						$signed(got.pos_x));
					errors++;
				end
				if (got.pos_y !== want.pos_y) begin
					$error("pos_y: expected %0d, got %0d", $signed(want.pos_y),
						$signed(got.pos_y));
					errors++;
				end
				if (got.frame_count !== want.frame_count) begin
					$error("frame_count: expected %0d, got %0d", want.frame_count,
						got.frame_count);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !arst_n)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_MAX) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic add_byte(input logic [7:0] b);
		byte_queue.push_back(b);
	endtask

	task automatic add_text(input string s);
		foreach (s[i])
			byte_queue.push_back(s[i]);
	endtask

	task automatic add_line(input string s);
		add_text(s);
		add_byte(CHAR_LF);
	endtask

	function automatic string num_text(input int v);
		string z;
		z = "";
		if ($urandom_range(99) < 15)
			repeat ($urandom_range(1, 3)) z = {z, "0"};
		if (v < 0)
			return {"-", z, "1"};
		return {z, $sformatf("%0d", v)};
	endfunction

	function automatic int pick_coord(input int lim);
		int top;
		top = (lim > 999) ? 999 : lim;
		case ($urandom_range(9))
			0:       return -1;
			1:       return top;
			2:       return (top < 999) ? top + 1 : 999;
			3:       return 0;
			4:       return $urandom_range(999);
			default: return $urandom_range(top);
		endcase
	endfunction

	task automatic add_random_line();
		string      s;
		logic [7:0] ln [$];
		int         k;
		int         x;
		int         y;
		int         n;
		k = $urandom_range(99);
		x = pick_coord(lim_x);
		y = (x < 0 && $urandom_range(1)) ? -1 : pick_coord(lim_y);
		s = {"BALL,", num_text(x), ",", num_text(y)};
		foreach (s[i])
			ln.push_back(s[i]);
		if (k < 70) begin
			if ($urandom_range(9) == 0)
				ln.insert($urandom_range(1, ln.size() - 1), CHAR_CR);
			foreach (ln[i])
				add_byte(ln[i]);
			if ($urandom_range(4) == 0)
				add_byte(CHAR_CR);
			add_byte(CHAR_LF);
		end else if (k < 80) begin
			n = $urandom_range(ln.size() - 1);
			case ($urandom_range(3))
				0:       ln[n] = CHAR_MINUS;
				1:       ln[n] = CHAR_COMMA;
				2:       ln[n] = 8'($urandom_range(255));
				default: ln = ln[0:n];
			endcase
			foreach (ln[i])
				add_byte(ln[i]);
			add_byte(CHAR_LF);
		end else if (k < 90) begin
			repeat ($urandom_range(1, 10)) add_byte(8'($urandom_range(255)));
			add_byte(CHAR_LF);
		end else if (k < 95) begin
			repeat ($urandom_range(24, 30)) add_byte(8'($urandom_range(32, 126)));
			add_byte(CHAR_LF);
		end else begin
			foreach (ln[i])
				add_byte(ln[i]);
			add_byte(CHAR_NUL);
			repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(32, 126)));
			add_byte(CHAR_LF);
		end
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MAX_X)
			lim_x = val;
		else
			lim_y = val;
	endtask

	task automatic wait_idle();
		while (byte_queue.size() != 0 || frames_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] x, input logic [CFG_W-1:0] y,
			input bit calm, input bit squeeze);
		write_reg(REG_MAX_X, x);
		write_reg(REG_MAX_Y, y);
		steady <= calm;
		if (squeeze)
			hold_req <= 1'b1;
		while (byte_queue.size() < PHASE_SIZE)
			add_random_line();
		wait_idle();
		steady <= 1'b0;
	endtask

	initial begin : main
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed lines at the reset limits 639 / 479
		add_line("BALL,0,0");
		add_line("BALL,639,479");
		add_line("BALL,640,479");
		add_line("BALL,639,480");
		add_line("BALL,-1,-1");
		add_line("BALL,-1,5");
		add_line("BALL,-01,-001");
		add_line("BALL,-2,-1");
		add_line("BALL,1000,1");
		add_text("BA");
		add_byte(CHAR_CR);
		add_text("LL,12,3");
		add_byte(CHAR_CR);
		add_byte(CHAR_LF);
		add_byte(CHAR_LF);
		add_line("BALL,0000000000001,0001");
		add_line("BALL,00000000000001,0001");
		add_line("BALL,5,5");
		add_text("BALL,7,8");
		add_byte(CHAR_NUL);
		add_line("zz");
		add_text("BALL,7");
		add_byte(CHAR_NUL);
		add_line(",8");
		add_line("ball,1,1");
		add_line("BALL,,1");
		add_line("BALL,1,2,");
		add_line("BALL,-,1");
		add_byte(8'hFF);
		add_line("BALL,9,9");
		wait_idle();

		run_phase(10'd999, 10'd999, 1'b0, 1'b1);
		run_phase(10'd0, 10'd0, 1'b1, 1'b0);
		run_phase(10'd1023, 10'd1023, 1'b0, 1'b0);
		run_phase(10'($urandom_range(1023)), 10'($urandom_range(1023)), 1'b0, 1'b0);
		run_phase(MAX_X_RESET, MAX_Y_RESET, 1'b0, 1'b0);

		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
